### src/tkz_pkg.sv
package tkz_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int FIELD_BITS  = 16;
   localparam int TAIL_BITS   = 48;
   localparam int WLEN_BITS   = 3;
   localparam logic [WLEN_BITS-1:0] WLEN_MAX = '1;
   localparam logic [WLEN_BITS-1:0] KW_MAX_LEN = 3'd6;

   localparam int MAX_TOKENS  = 3;
   localparam int COUNT_BITS  = $clog2(MAX_TOKENS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_EQ         = 8'h3D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   typedef enum logic [4:0] {
      KIND_ILLEGAL = 5'd0,
      KIND_END,
      KIND_IDENT,
      KIND_INT,
      KIND_STRING,
      KIND_ASSIGN,
      KIND_PLUS,
      KIND_MINUS,
      KIND_BANG,
      KIND_ASTERISK,
      KIND_SLASH,
      KIND_LT,
      KIND_GT,
      KIND_EQ_EQ,
      KIND_NOT_EQ,
      KIND_COMMA,
      KIND_SEMICOLON,
      KIND_LPAREN,
      KIND_RPAREN,
      KIND_LBRACE,
      KIND_RBRACE,
      KIND_LBRACKET,
      KIND_RBRACKET,
      KIND_FN,
      KIND_LET,
      KIND_TRUE,
      KIND_FALSE,
      KIND_IF,
      KIND_ELSE,
      KIND_RETURN
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] length;
   } token_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]        count;
      token_type [MAX_TOKENS-1:0]   tok;
   } burst_type;

   typedef struct packed {
      token_type tok;
      logic      last;
   } entry_type;

   localparam int KW_COUNT = 7;
   localparam logic [TAIL_BITS-1:0] KW_WORD [KW_COUNT] = '{
      48'h666E, 48'h6C6574, 48'h74727565, 48'h66616C7365,
      48'h6966, 48'h656C7365, 48'h72657475726E
   };
   localparam logic [WLEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd6
   };
   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_FN, KIND_LET, KIND_TRUE, KIND_FALSE, KIND_IF, KIND_ELSE, KIND_RETURN
   };

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
             (b == CH_UNDERSCORE);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
   endfunction

   function automatic kind_type single_kind(input logic [7:0] b);
      kind_type k;
      unique case (b)
         8'h2B:   k = KIND_PLUS;       // +
         8'h2D:   k = KIND_MINUS;      // -
         8'h2A:   k = KIND_ASTERISK;   // *
         8'h2F:   k = KIND_SLASH;      // /
         8'h3C:   k = KIND_LT;         // <
         8'h3E:   k = KIND_GT;         // >
         8'h2C:   k = KIND_COMMA;      // ,
         8'h3B:   k = KIND_SEMICOLON;  // ;
         8'h28:   k = KIND_LPAREN;     // (
         8'h29:   k = KIND_RPAREN;     // )
         8'h7B:   k = KIND_LBRACE;     // {
         8'h7D:   k = KIND_RBRACE;     // }
         8'h5B:   k = KIND_LBRACKET;   // [
         8'h5D:   k = KIND_RBRACKET;   // ]
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

   // Parallel compare of the identifier tail against every keyword.
   function automatic kind_type keyword_kind(input logic [TAIL_BITS-1:0] tail,
                                             input logic [WLEN_BITS-1:0] wlen);
      kind_type k;
      k = KIND_IDENT;
      if (wlen <= KW_MAX_LEN) begin
         for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (KW_LEN[i] == wlen && KW_WORD[i] == tail) begin
               k = KW_KIND[i];
            end
         end
      end
      return k;
   endfunction

endpackage

### src/source_text_tokenizer_top.sv
// Channel  Dir  Beat fields (tdata from bit 0 up)                   Marker
// req_     in   text_byte[7:0]                                       tlast = final_byte
// rsp_     out  token_kind[4:0] literal_start[20:5]                  tlast = run_last
//               literal_length[36:21], zero pad [39:37]
//
// One source byte per cycle while the step can fire. A byte beat lands in an
// input register; from there the lexer step turns it into 0..3 tokens, pushed into a
// 4-entry token queue that drives the rsp_ side one token per cycle while
// rsp_tready is high. The step fires while the queue holds at most one token;
// rsp_ stalls back up into req_tready.
// Reset (synchronous, high) empties both stages and restarts offsets at 0.
module source_text_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte[7:0]
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_kind[4:0], literal_start[20:5],
                                    // literal_length[36:21], zeros[39:37]
   output logic        rsp_tlast    // run_last
);
   import tkz_pkg::*;

   localparam int PAD_BITS = 40 - $bits(token_type);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  accept;
   logic                  step_en;
   burst_type             burst;
   entry_type             head;
   logic [QCNT_BITS-1:0]  level;

   // step only when the queue has room for a full burst
   assign step_en     = in_valid_ff && (level <= QCNT_BITS'(QUEUE_DEPTH - MAX_TOKENS));
   assign req_tready  = !in_valid_ff || step_en;
   assign accept      = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !step_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tkz_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .text_byte  (in_byte_ff),
      .final_byte (in_last_ff),
      .burst      (burst)
   );

   tkz_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_en),
      .burst     (burst),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_entry (head),
      .level     (level)
   );

   assign rsp_tdata = {{PAD_BITS{1'b0}}, head.tok.length, head.tok.start, head.tok.kind};
   assign rsp_tlast = head.last;

endmodule

### src/tkz_lexer.sv
module tkz_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          text_byte,
   input  logic                final_byte,
   output tkz_pkg::burst_type  burst
);
   import tkz_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUM,
      MODE_STR,
      MODE_EQ,
      MODE_BANG
   } mode_type;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   mode_type               mode_ff, mode_in, mode1, mode2;
   logic [OFFSET_BITS-1:0] start_ff, start_in, start1, start2;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in, end_pos;
   logic [TAIL_BITS-1:0]   tail_ff, tail_in, tail1, tail2;
   logic [WLEN_BITS-1:0]   wlen_ff, wlen_in, wlen1, wlen2;
   logic                   used;
   token_type              tok_a, tok_b, tok_c, tok_d;
   logic                   a_v, b_v, c_v;
   token_type              cand [MAX_TOKENS];
   logic [MAX_TOKENS-1:0]  cand_v;
   logic [COUNT_BITS-1:0]  cnt;

   function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
      return (v == OFF_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] from,
                                                   input logic [OFFSET_BITS-1:0] to);
      return (to >= from) ? to - from : '0;
   endfunction

   function automatic token_type mk_tok(input kind_type k,
                                        input logic [OFFSET_BITS-1:0] s,
                                        input logic [OFFSET_BITS-1:0] l);
      token_type t;
      t.kind   = k;
      t.start  = FIELD_BITS'(s);
      t.length = FIELD_BITS'(l);
      return t;
   endfunction

   function automatic token_type flush_tok(input mode_type m,
                                           input logic [OFFSET_BITS-1:0] s,
                                           input logic [OFFSET_BITS-1:0] e,
                                           input logic [TAIL_BITS-1:0] tail,
                                           input logic [WLEN_BITS-1:0] wlen);
      token_type t;
      unique case (m)
         MODE_IDENT: t = mk_tok(keyword_kind(tail, wlen), s, span(s, e));
         MODE_NUM:   t = mk_tok(KIND_INT, s, span(s, e));
         MODE_STR:   t = mk_tok(KIND_STRING, s, span(s, e));
         MODE_EQ:    t = mk_tok(KIND_ASSIGN, s, OFFSET_BITS'(1));
         MODE_BANG:  t = mk_tok(KIND_BANG, s, OFFSET_BITS'(1));
         default:    t = mk_tok(KIND_END, s, '0);
      endcase
      return t;
   endfunction

   always_comb begin
      // continue or close the open token
      mode1  = mode_ff;
      start1 = start_ff;
      tail1  = tail_ff;
      wlen1  = wlen_ff;
      used   = 1'b0;
      a_v    = 1'b0;
      tok_a  = flush_tok(mode_ff, start_ff, offset_ff, tail_ff, wlen_ff);
      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_letter(text_byte)) begin
               tail1 = {tail_ff[TAIL_BITS-9:0], text_byte};
               if (wlen_ff != WLEN_MAX) begin
                  wlen1 = wlen_ff + 1'b1;
               end
               used = 1'b1;
            end else begin
               a_v   = 1'b1;
               mode1 = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (is_digit(text_byte)) begin
               used = 1'b1;
            end else begin
               a_v   = 1'b1;
               mode1 = MODE_IDLE;
            end
         end
         MODE_EQ, MODE_BANG: begin
            a_v   = 1'b1;
            mode1 = MODE_IDLE;
            if (text_byte == CH_EQ) begin
               tok_a = mk_tok((mode_ff == MODE_EQ) ? KIND_EQ_EQ : KIND_NOT_EQ,
                              start_ff, OFFSET_BITS'(2));
               used  = 1'b1;
            end
         end
         MODE_STR: begin
            if (text_byte == CH_QUOTE || text_byte == CH_NUL) begin
               a_v   = 1'b1;
               mode1 = MODE_IDLE;
            end
            used = 1'b1;
         end
         default: mode1 = MODE_IDLE;
      endcase

      // byte not consumed: it may open a token or stand alone
      mode2  = mode1;
      start2 = start1;
      tail2  = tail1;
      wlen2  = wlen1;
      b_v    = 1'b0;
      tok_b  = mk_tok(KIND_END, offset_ff, '0);
      if (!used) begin
         priority if (is_space(text_byte)) begin
            b_v = 1'b0;
         end else if (text_byte == CH_EQ) begin
            mode2  = MODE_EQ;
            start2 = offset_ff;
         end else if (text_byte == CH_BANG) begin
            mode2  = MODE_BANG;
            start2 = offset_ff;
         end else if (is_letter(text_byte)) begin
            mode2  = MODE_IDENT;
            start2 = offset_ff;
            tail2  = TAIL_BITS'(text_byte);
            wlen2  = WLEN_BITS'(1);
         end else if (is_digit(text_byte)) begin
            mode2  = MODE_NUM;
            start2 = offset_ff;
         end else if (text_byte == CH_QUOTE) begin
            mode2  = MODE_STR;
            start2 = sat_inc(offset_ff);
         end else if (text_byte == CH_NUL) begin
            b_v = 1'b1;
         end else begin
            b_v   = 1'b1;
            tok_b = mk_tok(single_kind(text_byte), offset_ff,
                           (single_kind(text_byte) != KIND_ILLEGAL) ?
                           OFFSET_BITS'(1) : OFFSET_BITS'(0));
         end
      end

      // end of text: close what is open, then END one past the final byte
      end_pos = sat_inc(offset_ff);
      tok_c   = flush_tok(mode2, start2, end_pos, tail2, wlen2);
      c_v     = final_byte && (mode2 != MODE_IDLE);
      tok_d   = mk_tok(KIND_END, end_pos, '0);

      // a standalone byte leaves nothing open, so b and c never meet
      cand[0]   = tok_a;
      cand[1]   = b_v ? tok_b : tok_c;
      cand[2]   = tok_d;
      cand_v    = {final_byte, b_v | c_v, a_v};
      burst.tok = '0;
      cnt       = '0;
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (cand_v[i]) begin
            burst.tok[cnt[COUNT_BITS-1:0]] = cand[i];
            cnt = cnt + 1'b1;
         end
      end
      burst.count = cnt;

      if (final_byte) begin
         mode_in   = MODE_IDLE;
         start_in  = '0;
         offset_in = '0;
         tail_in   = '0;
         wlen_in   = '0;
      end else begin
         mode_in   = mode2;
         start_in  = start2;
         offset_in = end_pos;
         tail_in   = tail2;
         wlen_in   = wlen2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         tail_ff   <= '0;
         wlen_ff   <= '0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         tail_ff   <= tail_in;
         wlen_ff   <= wlen_in;
      end
   end

endmodule

### src/tkz_queue.sv
module tkz_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  tkz_pkg::burst_type             burst,
   input  logic                           out_ready,
   output logic                           out_valid,
   output tkz_pkg::entry_type             out_entry,
   output logic [tkz_pkg::QCNT_BITS-1:0]  level
);
   import tkz_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   level_ff, level_in;
   logic [COUNT_BITS-1:0]  n_push;
   logic                   pop;

   assign n_push    = push ? burst.count : '0;
   assign pop       = (level_ff != '0) && out_ready;
   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign level_in  = level_ff + QCNT_BITS'(n_push) - QCNT_BITS'(pop);

   assign out_valid = level_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
         if (COUNT_BITS'(i) < n_push) begin
            mem_ff[QPTR_BITS'(wr_ptr_ff + QPTR_BITS'(i))] <=
               '{tok: burst.tok[i], last: (COUNT_BITS'(i + 1) == n_push)};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

### src/tkz_checker.sv
module tkz_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   import tkz_pkg::*;

   // stalled token beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed under stall");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // END and ILLEGAL carry no literal
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:0] == KIND_END || rsp_tdata[4:0] == KIND_ILLEGAL)
      |-> rsp_tdata[36:21] == 16'd0)
      else $error("END/ILLEGAL with nonzero length");

   // an EQ_EQ or NOT_EQ token spans two bytes
   a_two_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:0] == KIND_EQ_EQ || rsp_tdata[4:0] == KIND_NOT_EQ)
      |-> rsp_tdata[36:21] == 16'd2 && rsp_tdata[39:37] == 3'd0)
      else $error("two-char operator with bad length");

endmodule

bind source_text_tokenizer_top tkz_checker u_tkz_checker (.*);
